[hdl/gcpm_pkg.sv]
// shared widths, codes, types and helpers of the genomic to coding position mapper
package gcpm_pkg;

	localparam int POS_BITS   = 30;
	localparam int MAX_EXONS  = 512;
	localparam int IDX_BITS   = $clog2(MAX_EXONS);
	localparam int CNT_BITS   = IDX_BITS + 1;
	localparam int PRE_BITS   = POS_BITS + IDX_BITS + 2;
	localparam int VAL_BITS   = PRE_BITS + 6;
	localparam int PT_BITS    = POS_BITS + 2;
	localparam int ID_BITS    = CNT_BITS + 1;
	localparam int SHOWN_BITS = 31;
	localparam int DIST_BITS  = 30;
	localparam int RAW_BITS   = 32;
	localparam int CFG_BITS   = 3;

	typedef logic [POS_BITS-1:0]        pos_t;
	typedef logic signed [PRE_BITS-1:0] pre_t;
	typedef logic signed [VAL_BITS-1:0] val_t;
	typedef logic signed [PT_BITS-1:0]  pt_t;

	// one located exon: slot, prefix length before it, bounds
	typedef struct packed {
		logic [IDX_BITS-1:0] idx;
		pre_t                pre;
		pos_t                xs;
		pos_t                xe;
	} loc_t;

	// everything the table walk hands to the arithmetic
	typedef struct packed {
		loc_t a;
		loc_t b;
		loc_t c;
		logic c_hit;
		loc_t j;
		pos_t nx_xs;
		pre_t nx_pre;
	} scan_res_t;

	typedef enum logic [CFG_BITS-1:0] {
		CFG_TX_START = 3'd0,
		CFG_TX_END   = 3'd1,
		CFG_CD_START = 3'd2,
		CFG_CD_END   = 3'd3,
		CFG_REVERSE  = 3'd4,
		CFG_COUNT    = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CODING = 2'd0,
		REG_UP     = 2'd1,
		REG_DOWN   = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		MARK_NONE  = 2'd0,
		MARK_PLUS  = 2'd1,
		MARK_MINUS = 2'd2
	} mark_t;

	function automatic val_t zx(input pos_t x);
		return {{(VAL_BITS-POS_BITS){1'b0}}, x};
	endfunction

	function automatic val_t sx(input pre_t v);
		return {{(VAL_BITS-PRE_BITS){v[PRE_BITS-1]}}, v};
	endfunction

	function automatic pre_t zp(input pos_t x);
		return {{(PRE_BITS-POS_BITS){1'b0}}, x};
	endfunction

	function automatic pt_t px(input pos_t x);
		return {{(PT_BITS-POS_BITS){1'b0}}, x};
	endfunction

endpackage

[hdl/genomic_to_coding_position_mapper_unit.sv]
// top level of the genomic to coding position mapper: registers, sequencing and arithmetic
//
// A load request writes one exon into the start and end tables and gives no result. A
// query request walks the tables once, one entry per cycle through the single read port
// of each memory; that walk through the table memory sets most of a query's length. The
// next request can be taken in the same cycle in which the result is offered. A result
// held back by the receiver keeps the last step waiting. The input side takes a request
// whenever no query is in flight, also while a finished result still waits on the output
// register. Slots that were never loaded read back as anything and must not be touched
// by a query.
module genomic_to_coding_position_mapper_unit import gcpm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_BITS-1:0]        cfg_index,
	input  logic [POS_BITS-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       command,
	input  logic [IDX_BITS-1:0]        exon_index,
	input  logic [POS_BITS-1:0]        exon_begin,
	input  logic [POS_BITS-1:0]        exon_finish,
	input  logic [POS_BITS-1:0]        query_pos,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 region_class,
	output logic [SHOWN_BITS-1:0]      shown_number,
	output logic [1:0]                 intron_mark,
	output logic [DIST_BITS-1:0]       intron_distance,
	output logic signed [RAW_BITS-1:0] coding_pos_raw,
	output logic signed [ID_BITS-1:0]  exon_number,
	output logic                       inside_transcript,
	output logic                       on_exon,
	output logic                       inside_coding
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC0,
		ST_CALC1,
		ST_CALC2,
		ST_CALC3,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PC_DOWN,
		PC_UP,
		PC_IN
	} pcase_t;

	// configuration
	pos_t                ts_q, te_q, cs_q, ce_q;
	logic                rev_q;
	logic [CNT_BITS-1:0] cnt_q;

	state_t              state_q;
	pcase_t              pc_q;
	pos_t                p_q;
	pt_t                 ptc_q;
	logic [CNT_BITS-1:0] n_q;

	val_t anchor_q, dnext_q, dprev_q, tbase_q, mid_q;
	val_t endoff_q, raw_q, cn_q, cj_q, clen_q, c_q, num_q, dist_q;
	logic near_q;
	logic [1:0] cls_q, mark_q;
	logic signed [ID_BITS-1:0] id_q;

	logic                       out_valid_q;
	logic [1:0]                 o_cls_q, o_mark_q;
	logic [SHOWN_BITS-1:0]      o_num_q;
	logic [DIST_BITS-1:0]       o_dist_q;
	logic signed [RAW_BITS-1:0] o_raw_q;
	logic signed [ID_BITS-1:0]  o_id_q;
	logic                       o_intx_q, o_onx_q, o_incd_q;

	logic      accept;
	logic      is_query;
	logic      scan_done;
	scan_res_t res;
	pt_t       pt_a, pt_b;
	logic      out_free;
	logic [CNT_BITS-1:0] n_in;

	assign accept   = in_valid && !in_stall;
	assign is_query = (command == CMD_QUERY);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign pt_a     = px(cs_q);
	assign pt_b     = px(ce_q) - pt_t'(1);

	// exon count held within one and the table depth
	always_comb begin
		if (cnt_q == '0) begin
			n_in = CNT_BITS'(1);
		end else if (cnt_q > CNT_BITS'(MAX_EXONS)) begin
			n_in = CNT_BITS'(MAX_EXONS);
		end else begin
			n_in = cnt_q;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= '0;
			te_q  <= '0;
			cs_q  <= '0;
			ce_q  <= '0;
			rev_q <= 1'b0;
			cnt_q <= CNT_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TX_START: ts_q  <= cfg_data;
				CFG_TX_END:   te_q  <= cfg_data;
				CFG_CD_START: cs_q  <= cfg_data;
				CFG_CD_END:   ce_q  <= cfg_data;
				CFG_REVERSE:  rev_q <= cfg_data[0];
				CFG_COUNT:    cnt_q <= cfg_data[CNT_BITS-1:0];
				default:      ;
			endcase
		end
	end

	gcpm_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept && !is_query),
		.wr_idx    (exon_index),
		.wr_begin  (exon_begin),
		.wr_finish (exon_finish),
		.start     (accept && is_query),
		.count     (n_in),
		.pt_a      (pt_a),
		.pt_b      (pt_b),
		.pt_c      (ptc_q),
		.done      (scan_done),
		.res       (res)
	);

	// query sequencing, arithmetic steps and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && is_query) begin
						p_q     <= query_pos;
						n_q     <= n_in;
						state_q <= ST_SCAN;
						if (query_pos >= te_q) begin
							pc_q  <= PC_DOWN;
							ptc_q <= px(te_q) - pt_t'(1);
						end else if (query_pos < ts_q) begin
							pc_q  <= PC_UP;
							ptc_q <= px(ts_q);
						end else begin
							pc_q  <= PC_IN;
							ptc_q <= px(query_pos);
						end
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_CALC0;
					end
				end
				ST_CALC0: begin
					anchor_q <= sx(res.a.pre) + zx(cs_q) - zx(res.a.xs);
					dnext_q  <= zx(res.nx_xs) - zx(p_q);
					dprev_q  <= zx(p_q) - zx(res.j.xe) + val_t'(1);
					case (pc_q)
						PC_DOWN: tbase_q <= sx(res.c.pre) - zx(res.c.xs) + zx(te_q);
						PC_UP:   tbase_q <= sx(res.c.pre) - zx(res.c.xs) + zx(ts_q) + val_t'(1);
						default: tbase_q <= sx(res.c.pre) - zx(res.c.xs) + zx(p_q) + val_t'(1);
					endcase
					if ({1'b0, res.b.idx} > ({1'b0, res.a.idx} + CNT_BITS'(1))) begin
						mid_q <= sx(res.b.pre) - sx(res.a.pre) - zx(res.a.xe) + zx(res.a.xs);
					end else begin
						mid_q <= '0;
					end
					state_q <= ST_CALC1;
				end
				ST_CALC1: begin
					endoff_q <= sx(res.b.pre) - anchor_q + zx(ce_q) - zx(res.b.xs);
					raw_q    <= tbase_q - anchor_q;
					cn_q     <= sx(res.nx_pre) - anchor_q + val_t'(1);
					cj_q     <= sx(res.j.pre) + zx(res.j.xe) - zx(res.j.xs) - anchor_q;
					near_q   <= dnext_q < dprev_q;
					if (res.a.idx == res.b.idx) begin
						clen_q <= zx(ce_q) - zx(cs_q);
					end else begin
						clen_q <= mid_q + zx(res.a.xe) - zx(cs_q) + zx(ce_q) - zx(res.b.xs);
					end
					state_q <= ST_CALC2;
				end
				ST_CALC2: begin
					mark_q <= MARK_NONE;
					dist_q <= '0;
					id_q   <= '1;
					case (pc_q)
						PC_DOWN: c_q <= raw_q + zx(p_q) - zx(te_q) + val_t'(1);
						PC_UP:   c_q <= raw_q - zx(ts_q) + zx(p_q);
						default: begin
							if (res.c_hit) begin
								c_q  <= raw_q;
								id_q <= rev_q ? ID_BITS'({1'b0, n_q} - {2'b00, res.c.idx})
								              : ID_BITS'({2'b00, res.c.idx} + ID_BITS'(1));
							end else if (near_q) begin
								c_q    <= cn_q;
								raw_q  <= cn_q;
								dist_q <= dnext_q;
								mark_q <= rev_q ? MARK_PLUS : MARK_MINUS;
								id_q   <= rev_q ? ID_BITS'({1'b0, n_q} - {2'b00, res.j.idx}
								                  - ID_BITS'(1))
								              : ID_BITS'({2'b00, res.j.idx} + ID_BITS'(2));
							end else begin
								c_q    <= cj_q;
								raw_q  <= cj_q;
								dist_q <= dprev_q;
								mark_q <= rev_q ? MARK_MINUS : MARK_PLUS;
								id_q   <= rev_q ? ID_BITS'({1'b0, n_q} - {2'b00, res.j.idx})
								              : ID_BITS'({2'b00, res.j.idx} + ID_BITS'(1));
							end
						end
					endcase
					state_q <= ST_CALC3;
				end
				ST_CALC3: begin
					// utr prefix and shown magnitude
					if (c_q > endoff_q) begin
						cls_q <= rev_q ? REG_UP : REG_DOWN;
						num_q <= c_q - endoff_q;
					end else if (c_q <= val_t'(0)) begin
						cls_q <= rev_q ? REG_DOWN : REG_UP;
						num_q <= val_t'(1) - c_q;
					end else begin
						cls_q <= REG_CODING;
						num_q <= rev_q ? clen_q + val_t'(1) - c_q : c_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						o_cls_q     <= cls_q;
						o_mark_q    <= mark_q;
						o_id_q      <= id_q;
						o_intx_q    <= (pc_q == PC_IN);
						o_onx_q     <= (pc_q == PC_IN) && res.c_hit;
						o_incd_q    <= (pc_q == PC_IN) && (p_q >= cs_q) && (p_q < ce_q);
						if (num_q[VAL_BITS-1]) begin
							o_num_q <= '0;
						end else if (|num_q[VAL_BITS-2:SHOWN_BITS]) begin
							o_num_q <= '1;
						end else begin
							o_num_q <= num_q[SHOWN_BITS-1:0];
						end
						if (dist_q[VAL_BITS-1]) begin
							o_dist_q <= '0;
						end else if (|dist_q[VAL_BITS-2:DIST_BITS]) begin
							o_dist_q <= '1;
						end else begin
							o_dist_q <= dist_q[DIST_BITS-1:0];
						end
						if (&raw_q[VAL_BITS-1:RAW_BITS-1] || !(|raw_q[VAL_BITS-1:RAW_BITS-1])) begin
							o_raw_q <= raw_q[RAW_BITS-1:0];
						end else if (raw_q[VAL_BITS-1]) begin
							o_raw_q <= {1'b1, {(RAW_BITS-1){1'b0}}};
						end else begin
							o_raw_q <= {1'b0, {(RAW_BITS-1){1'b1}}};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign region_class      = o_cls_q;
	assign shown_number      = o_num_q;
	assign intron_mark       = o_mark_q;
	assign intron_distance   = o_dist_q;
	assign coding_pos_raw    = o_raw_q;
	assign exon_number       = o_id_q;
	assign inside_transcript = o_intx_q;
	assign on_exon           = o_onx_q;
	assign inside_coding     = o_incd_q;

`ifndef ASSERT_OFF
	// the walk only finishes while a query waits on it
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> state_q == ST_SCAN)
		else $error("table walk finished outside a query");

	// a fresh result only comes from the final step
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result appeared without a finished query");

	// the exon count in use stays within the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> (n_q != '0 && n_q <= CNT_BITS'(MAX_EXONS)))
		else $error("exon count in use out of range");

	// a query is followed by its walk
	a_query_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_query |=> state_q == ST_SCAN)
		else $error("query accepted without starting the walk");
`endif

endmodule

[hdl/gcpm_scan.sv]
// exon tables and the sequential walk that locates points and accumulates exon lengths
module gcpm_scan import gcpm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_BITS-1:0] wr_idx,
	input  pos_t                wr_begin,
	input  pos_t                wr_finish,
	input  logic                start,
	input  logic [CNT_BITS-1:0] count,
	input  pt_t                 pt_a,
	input  pt_t                 pt_b,
	input  pt_t                 pt_c,
	output logic                done,
	output scan_res_t           res
);

	pos_t start_mem [MAX_EXONS];
	pos_t end_mem   [MAX_EXONS];

	logic [CNT_BITS-1:0] issue_q;
	logic                busy_q;
	logic                vld_s1;
	logic [IDX_BITS-1:0] idx_s1;
	pos_t                xs_s1;
	pos_t                xe_s1;
	logic                done_q;
	pre_t                pre_q;
	loc_t                prev_q;
	loc_t                hit_q  [3];
	loc_t                last_q [3];
	logic [2:0]          hf_q;
	loc_t                j_q;
	logic                jf_q;
	pos_t                nx_xs_q;
	pre_t                nx_pre_q;

	logic                rd_en;
	logic [IDX_BITS-1:0] rd_addr;
	loc_t                cur;
	pt_t                 pts [3];
	logic                last_el;
	logic                jcond;
	logic                gap;

	assign rd_en   = busy_q && (issue_q < count);
	assign rd_addr = issue_q[IDX_BITS-1:0];
	assign cur     = '{idx: idx_s1, pre: pre_q, xs: xs_s1, xe: xe_s1};
	assign pts[0]  = pt_a;
	assign pts[1]  = pt_b;
	assign pts[2]  = pt_c;
	assign last_el = ({1'b0, idx_s1} == (count - CNT_BITS'(1)));
	assign jcond   = px(prev_q.xe) <= pt_c;
	assign gap     = jcond && (pt_c < px(xs_s1));

	// table write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			start_mem[wr_idx] <= wr_begin;
			end_mem[wr_idx]   <= wr_finish;
		end
		if (rd_en) begin
			xs_s1 <= start_mem[rd_addr];
			xe_s1 <= end_mem[rd_addr];
		end
	end

	// walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
			hf_q    <= '0;
			jf_q    <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			done_q <= vld_s1 && last_el;
			if (start) begin
				busy_q  <= 1'b1;
				issue_q <= '0;
				hf_q    <= '0;
				jf_q    <= 1'b0;
			end else begin
				if (rd_en) begin
					issue_q <= issue_q + CNT_BITS'(1);
				end
				if (vld_s1 && last_el) begin
					busy_q <= 1'b0;
				end
				if (vld_s1) begin
					for (int k = 0; k < 3; k++) begin
						if (!hf_q[k] && px(xs_s1) <= pts[k] && pts[k] < px(xe_s1)) begin
							hf_q[k] <= 1'b1;
						end
					end
					if (idx_s1 != '0 && !jf_q && gap) begin
						jf_q <= 1'b1;
					end
				end
			end
		end
	end

	// per element capture and running prefix sum
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_addr;
		end
		if (start) begin
			pre_q <= '0;
		end else if (vld_s1) begin
			pre_q  <= pre_q + zp(xe_s1) - zp(xs_s1);
			prev_q <= cur;
			for (int k = 0; k < 3; k++) begin
				if (!hf_q[k] && px(xs_s1) <= pts[k] && pts[k] < px(xe_s1)) begin
					hit_q[k] <= cur;
				end
				if (idx_s1 == '0 || px(xs_s1) <= pts[k]) begin
					last_q[k] <= cur;
				end
			end
			// exon before the gap that holds the point, else the last one behind it
			if (idx_s1 == '0) begin
				j_q      <= cur;
				nx_xs_q  <= xs_s1;
				nx_pre_q <= pre_q;
			end else if (!jf_q && (idx_s1 == IDX_BITS'(1) || jcond)) begin
				j_q      <= prev_q;
				nx_xs_q  <= xs_s1;
				nx_pre_q <= pre_q;
			end
		end
	end

	assign done       = done_q;
	assign res.a      = hf_q[0] ? hit_q[0] : last_q[0];
	assign res.b      = hf_q[1] ? hit_q[1] : last_q[1];
	assign res.c      = hf_q[2] ? hit_q[2] : last_q[2];
	assign res.c_hit  = hf_q[2];
	assign res.j      = j_q;
	assign res.nx_xs  = nx_xs_q;
	assign res.nx_pre = nx_pre_q;

endmodule
